@@ sv/flc_pkg.sv @@
// shared types, constants and widths for the framed cover layout block
`default_nettype none
package flc_pkg;

  localparam int DimBits  = 14;
  localparam int FracBits = 4;
  localparam int PosBits  = DimBits + FracBits;
  localparam int NumBits  = 2 * DimBits + FracBits;
  localparam int RemBits  = DimBits + 1;
  localparam int ProdBits = 2 * DimBits;
  localparam int ScaleBits = 7;
  localparam int CmpBits  = DimBits + ScaleBits;
  localparam int PadBits  = 5;
  localparam int NumRegs  = 6;
  localparam int RegIdxBits = 3;
  localparam int AddrBits = 5;
  localparam int DataBits = 32;

  localparam logic [ScaleBits-1:0] ScaleUnit  = ScaleBits'(100);
  localparam logic [ScaleBits-1:0] ScaleLand  = ScaleBits'(115);
  localparam logic [ScaleBits-1:0] ScalePort  = ScaleBits'(87);

  localparam logic [PadBits-1:0] PadSquare    = PadBits'(30);
  localparam logic [PadBits-1:0] PadPortrait  = PadBits'(10);
  localparam logic [PadBits-1:0] PadLandscape = PadBits'(15);

  localparam logic [PosBits:0] HalfPix = (PosBits+1)'((1 << FracBits) >> 1);

  typedef enum logic [RegIdxBits-1:0] {
    RegSqW   = 3'd0,
    RegSqH   = 3'd1,
    RegPortW = 3'd2,
    RegPortH = 3'd3,
    RegLandW = 3'd4,
    RegLandH = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    OrSquare    = 2'd0,
    OrPortrait  = 2'd1,
    OrLandscape = 2'd2,
    OrNone      = 2'd3
  } orient_e;

  typedef struct packed {
    logic [DimBits-1:0] art_width;
    logic [DimBits-1:0] art_height;
  } req_t;

  typedef struct packed {
    logic [DimBits-1:0] box_width;
    logic [DimBits-1:0] box_height;
    logic [1:0]         orientation;
    logic               frame_drawn;
    logic [PosBits-1:0] frame_x;
    logic [PosBits-1:0] frame_y;
    logic [PosBits-1:0] frame_w;
    logic [PosBits-1:0] frame_h;
    logic [PosBits-1:0] art_x;
    logic [PosBits-1:0] art_y;
    logic [PosBits-1:0] art_w;
    logic [PosBits-1:0] art_h;
  } res_t;

  typedef struct packed {
    logic [DimBits-1:0] sq_w;
    logic [DimBits-1:0] sq_h;
    logic [DimBits-1:0] port_w;
    logic [DimBits-1:0] port_h;
    logic [DimBits-1:0] land_w;
    logic [DimBits-1:0] land_h;
  } cfg_t;

  typedef struct packed {
    logic [PosBits-1:0] x;
    logic [PosBits-1:0] y;
    logic [PosBits-1:0] w;
    logic [PosBits-1:0] h;
  } rect_t;

  typedef struct packed {
    logic [DimBits-1:0] box_w;
    logic [DimBits-1:0] box_h;
    orient_e            orient;
    logic               framed;
    logic [PadBits-1:0] pad;
    logic [DimBits-1:0] aw;
    logic [DimBits-1:0] ah;
    rect_t              frame;
    logic [PosBits-1:0] area_x;
    logic [PosBits-1:0] area_y;
  } ctx_t;

  typedef struct packed {
    logic [DimBits-1:0] bw;
    logic [DimBits-1:0] bh;
    logic [DimBits-1:0] tw;
    logic [DimBits-1:0] th;
    ctx_t               ctx;
  } fit_in_t;

  typedef struct packed {
    ctx_t               ctx;
    logic [DimBits-1:0] bw;
    logic [DimBits-1:0] bh;
    logic               hcase;
    logic               degen;
  } fit_side_t;

endpackage
`default_nettype wire

@@ sv/flc_cfg.sv @@
// border size registers behind the apb-style configuration port
`default_nettype none
module flc_cfg import flc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic      [DataBits-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr;
  logic [DimBits-1:0] wval;
  logic [DimBits-1:0] rval;
  reg_idx_e idx;

  assign wr    = psel && penable && pwrite;
  assign wval  = pwdata[DimBits-1:0];
  assign idx   = reg_idx_e'(paddr[AddrBits-1:2]);
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    rval  = '0;
    unique case (idx)
      RegSqW:   begin rval = cfg_q.sq_w;   if (wr) cfg_d.sq_w   = wval; end
      RegSqH:   begin rval = cfg_q.sq_h;   if (wr) cfg_d.sq_h   = wval; end
      RegPortW: begin rval = cfg_q.port_w; if (wr) cfg_d.port_w = wval; end
      RegPortH: begin rval = cfg_q.port_h; if (wr) cfg_d.port_h = wval; end
      RegLandW: begin rval = cfg_q.land_w; if (wr) cfg_d.land_w = wval; end
      RegLandH: begin rval = cfg_q.land_h; if (wr) cfg_d.land_h = wval; end
      default:  rval = '0;
    endcase
  end

  assign prdata = DataBits'(rval);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/flc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module flc_div import flc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic [NumBits-1:0] num_i,
  input  wire logic [DimBits-1:0] den_i,
  input  fit_side_t               side_i,
  output logic                    out_valid_o,
  output logic      [PosBits-1:0] quo_o,
  output fit_side_t               side_o
);

  logic [PosBits:0]   v_q;
  logic [RemBits-1:0] r_q [PosBits+1];
  logic [PosBits-1:0] n_q [PosBits+1];
  logic [PosBits-1:0] q_q [PosBits+1];
  logic [DimBits-1:0] d_q [PosBits+1];
  fit_side_t          s_q [PosBits+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[PosBits-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0] <= RemBits'(num_i[NumBits-1 -: DimBits]);
    n_q[0] <= num_i[PosBits-1:0];
    q_q[0] <= '0;
    d_q[0] <= den_i;
    s_q[0] <= side_i;
  end

  for (genvar k = 0; k < PosBits; k++) begin : g_stage
    logic [RemBits-1:0] trial;
    logic               ge;
    assign trial = {r_q[k][DimBits-1:0], n_q[k][PosBits-1]};
    assign ge    = trial >= {1'b0, d_q[k]};
    always_ff @(posedge clk_i) begin
      r_q[k+1] <= ge ? trial - {1'b0, d_q[k]} : trial;
      n_q[k+1] <= n_q[k] << 1;
      q_q[k+1] <= {q_q[k][PosBits-2:0], ge};
      d_q[k+1] <= d_q[k];
      s_q[k+1] <= s_q[k];
    end
  end

  assign out_valid_o = v_q[PosBits];
  assign quo_o       = q_q[PosBits];
  assign side_o      = s_q[PosBits];

endmodule
`default_nettype wire

@@ sv/flc_fit.sv @@
// centred aspect fit of one image into a box, pipelined around the divider
`default_nettype none
module flc_fit import flc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  fit_in_t   in_i,
  output logic      out_valid_o,
  output rect_t     rect_o,
  output ctx_t      ctx_o
);

  logic                v1_q;
  fit_in_t             f1_q;
  logic [ProdBits-1:0] p_tb_q, p_hw_q;

  logic                degen, hcase;
  logic [NumBits-1:0]  num;
  logic [DimBits-1:0]  den;
  fit_side_t           side;

  logic                dv;
  logic [PosBits-1:0]  quo;
  fit_side_t           dside;

  logic [PosBits-1:0]  bw16, bh16;
  rect_t               rect_d;
  logic                vo_q;
  rect_t               rect_q;
  ctx_t                ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      vo_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_q   <= in_i;
    p_tb_q <= ProdBits'(in_i.tw) * ProdBits'(in_i.bh);
    p_hw_q <= ProdBits'(in_i.th) * ProdBits'(in_i.bw);
  end

  always_comb begin
    degen = (f1_q.bw == '0) || (f1_q.bh == '0) || (f1_q.tw == '0) || (f1_q.th == '0);
    hcase = p_tb_q > p_hw_q;
    num   = hcase ? {p_hw_q, FracBits'(0)} : {p_tb_q, FracBits'(0)};
    if (degen) begin
      den = DimBits'(1);
    end else begin
      den = hcase ? f1_q.tw : f1_q.th;
    end
    side.ctx   = f1_q.ctx;
    side.bw    = f1_q.bw;
    side.bh    = f1_q.bh;
    side.hcase = hcase;
    side.degen = degen;
  end

  flc_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .num_i       (num),
    .den_i       (den),
    .side_i      (side),
    .out_valid_o (dv),
    .quo_o       (quo),
    .side_o      (dside)
  );

  always_comb begin
    bw16   = {dside.bw, FracBits'(0)};
    bh16   = {dside.bh, FracBits'(0)};
    rect_d = '{x: '0, y: '0, w: bw16, h: bh16};
    if (!dside.degen) begin
      if (dside.hcase) begin
        rect_d.h = quo;
        rect_d.y = (bh16 - quo) >> 1;
      end else begin
        rect_d.w = quo;
        rect_d.x = (bw16 - quo) >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rect_q <= rect_d;
    ctx_q  <= dside.ctx;
  end

  assign out_valid_o = vo_q;
  assign rect_o      = rect_q;
  assign ctx_o       = ctx_q;

endmodule
`default_nettype wire

@@ sv/framed_cover_layout.sv @@
// framed cover layout top level: classify, border fit, padding, cover fit
//
// channel   direction  handshake           payload
// request   in         start, busy         req_i (art_width, art_height)
// result    out        done_o strobe       res_o (box, orientation, frame, art)
// config    in         psel/penable/pwrite paddr, pwdata, prdata
//
// one transaction enters every cycle; busy is never raised
// a result passes the request register, the classify register, the frame fit, the padding
// register, the art fit and the output register; each fit unit holds an 18-stage divider
// reset clears the border registers and all valid bits
// results are strobed for one cycle and cannot be held off
`default_nettype none
module framed_cover_layout import flc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  req_t                     req_i,
  output logic                     done_o,
  output res_t                     res_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic      [DataBits-1:0] prdata,
  output logic                     pready
);

  cfg_t cfg;

  logic               v0_q;
  logic [DimBits-1:0] aw0_q, ah0_q;
  logic [CmpBits-1:0] w100_q, h115_q, h87_q;

  logic               v1_q;
  fit_in_t            f1_d, f1_q;

  logic               fv1;
  rect_t              frame;
  ctx_t               c1;

  logic               v2_q;
  fit_in_t            f2_d, f2_q;

  logic               fv2;
  rect_t              art;
  ctx_t               c2;

  logic               vo_q;
  res_t               res_d, res_q;

  assign busy = 1'b0;

  flc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
      v2_q <= fv1;
      vo_q <= fv2;
    end
  end

  always_ff @(posedge clk_i) begin
    aw0_q  <= req_i.art_width;
    ah0_q  <= req_i.art_height;
    w100_q <= CmpBits'(req_i.art_width) * CmpBits'(ScaleUnit);
    h115_q <= CmpBits'(req_i.art_height) * CmpBits'(ScaleLand);
    h87_q  <= CmpBits'(req_i.art_height) * CmpBits'(ScalePort);
  end

  // classify and pick border and box
  always_comb begin
    logic [DimBits-1:0] sel_w, sel_h;
    logic               has_b, sq_set;
    f1_d  = '0;
    sel_w = '0;
    sel_h = '0;
    if (ah0_q == '0) begin
      f1_d.ctx.orient = OrNone;
      f1_d.ctx.pad    = '0;
    end else if (w100_q > h115_q) begin
      f1_d.ctx.orient = OrLandscape;
      f1_d.ctx.pad    = PadLandscape;
      sel_w = cfg.land_w;
      sel_h = cfg.land_h;
    end else if (w100_q < h87_q) begin
      f1_d.ctx.orient = OrPortrait;
      f1_d.ctx.pad    = PadPortrait;
      sel_w = cfg.port_w;
      sel_h = cfg.port_h;
    end else begin
      f1_d.ctx.orient = OrSquare;
      f1_d.ctx.pad    = PadSquare;
      sel_w = cfg.sq_w;
      sel_h = cfg.sq_h;
    end
    has_b  = (sel_w != '0) && (sel_h != '0);
    sq_set = (cfg.sq_w != '0) && (cfg.sq_h != '0);
    if (sq_set) begin
      f1_d.bw = cfg.sq_w;
      f1_d.bh = cfg.sq_h;
    end else if (has_b) begin
      f1_d.bw = sel_w;
      f1_d.bh = sel_h;
    end else begin
      f1_d.bw = aw0_q;
      f1_d.bh = ah0_q;
    end
    f1_d.tw         = has_b ? sel_w : '0;
    f1_d.th         = has_b ? sel_h : '0;
    f1_d.ctx.box_w  = f1_d.bw;
    f1_d.ctx.box_h  = f1_d.bh;
    f1_d.ctx.framed = has_b;
    f1_d.ctx.aw     = aw0_q;
    f1_d.ctx.ah     = ah0_q;
  end

  always_ff @(posedge clk_i) begin
    f1_q <= f1_d;
  end

  flc_fit u_fit_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_i        (f1_q),
    .out_valid_o (fv1),
    .rect_o      (frame),
    .ctx_o       (c1)
  );

  // padding and rounding to whole pixels
  always_comb begin
    logic [PosBits-1:0] p;
    logic [PosBits:0]   two_p;
    logic [PosBits-1:0] ax, ay, aw_a, ah_a;
    logic [PosBits:0]   rw, rh;
    p     = PosBits'(c1.pad) << FracBits;
    two_p = {p, 1'b0};
    ax    = frame.x;
    ay    = frame.y;
    aw_a  = frame.w;
    ah_a  = frame.h;
    if (c1.framed && ({1'b0, frame.w} > two_p) && ({1'b0, frame.h} > two_p)) begin
      ax   = frame.x + p;
      ay   = frame.y + p;
      aw_a = frame.w - two_p[PosBits-1:0];
      ah_a = frame.h - two_p[PosBits-1:0];
    end
    rw = {1'b0, aw_a} + HalfPix;
    rh = {1'b0, ah_a} + HalfPix;
    f2_d            = '0;
    f2_d.ctx        = c1;
    f2_d.ctx.frame  = frame;
    f2_d.ctx.area_x = ax;
    f2_d.ctx.area_y = ay;
    f2_d.bw         = rw[FracBits +: DimBits];
    f2_d.bh         = rh[FracBits +: DimBits];
    f2_d.tw         = c1.aw;
    f2_d.th         = c1.ah;
  end

  always_ff @(posedge clk_i) begin
    f2_q <= f2_d;
  end

  flc_fit u_fit_art (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v2_q),
    .in_i        (f2_q),
    .out_valid_o (fv2),
    .rect_o      (art),
    .ctx_o       (c2)
  );

  always_comb begin
    res_d.box_width   = c2.box_w;
    res_d.box_height  = c2.box_h;
    res_d.orientation = c2.orient;
    res_d.frame_drawn = c2.framed;
    res_d.frame_x     = c2.frame.x;
    res_d.frame_y     = c2.frame.y;
    res_d.frame_w     = c2.frame.w;
    res_d.frame_h     = c2.frame.h;
    res_d.art_x       = art.x + c2.area_x;
    res_d.art_y       = art.y + c2.area_y;
    res_d.art_w       = art.w;
    res_d.art_h       = art.h;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = vo_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// testbench for the framed cover layout block: directed and random layouts
`default_nettype none
module testbench import flc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 46;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  res_t res_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [DataBits-1:0] pwdata = '0;
  logic [DataBits-1:0] prdata;
  logic pready;

  framed_cover_layout dut (.*);

  always #4 clk_i = ~clk_i;

  cfg_t borders;
  res_t layouts_due[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;

  typedef struct {
    longint x;
    longint y;
    longint w;
    longint h;
  } box_rect_t;

  function automatic box_rect_t fit_centred(longint bw, longint bh, longint tw, longint th);
    box_rect_t r;
    r.x = 0;
    r.y = 0;
    r.w = bw << FracBits;
    r.h = bh << FracBits;
    if (bw == 0 || bh == 0 || tw == 0 || th == 0) return r;
    if (tw * bh > th * bw) begin
      r.h = ((bw * th) << FracBits) / tw;
      r.y = ((bh << FracBits) - r.h) >> 1;
    end else begin
      r.w = ((bh * tw) << FracBits) / th;
      r.x = ((bw << FracBits) - r.w) >> 1;
    end
    return r;
  endfunction

  function automatic res_t predict_layout(req_t rq);
    res_t o;
    longint aw, ah, sw, sh, pad, bw, bh, p;
    orient_e orient;
    bit drawn, sq_set;
    box_rect_t fr, ar, cv;
    aw = rq.art_width;
    ah = rq.art_height;
    sw = 0;
    sh = 0;
    pad = 0;
    if (ah == 0) begin
      orient = OrNone;
    end else if (aw * 100 > ah * 115) begin
      orient = OrLandscape;
      sw = borders.land_w;
      sh = borders.land_h;
      pad = 15;
    end else if (aw * 100 < ah * 87) begin
      orient = OrPortrait;
      sw = borders.port_w;
      sh = borders.port_h;
      pad = 10;
    end else begin
      orient = OrSquare;
      sw = borders.sq_w;
      sh = borders.sq_h;
      pad = 30;
    end
    drawn = sw != 0 && sh != 0;
    sq_set = borders.sq_w != 0 && borders.sq_h != 0;
    if (sq_set) begin
      bw = borders.sq_w;
      bh = borders.sq_h;
    end else if (drawn) begin
      bw = sw;
      bh = sh;
    end else begin
      bw = aw;
      bh = ah;
    end
    fr = drawn ? fit_centred(bw, bh, sw, sh) : fit_centred(bw, bh, 0, 0);
    ar = fr;
    if (drawn) begin
      p = pad << FracBits;
      if (ar.w > 2 * p && ar.h > 2 * p) begin
        ar.x += p;
        ar.y += p;
        ar.w -= 2 * p;
        ar.h -= 2 * p;
      end
    end
    cv = fit_centred((ar.w + 8) >> FracBits, (ar.h + 8) >> FracBits, aw, ah);
    o.box_width = bw[DimBits-1:0];
    o.box_height = bh[DimBits-1:0];
    o.orientation = orient;
    o.frame_drawn = drawn;
    o.frame_x = fr.x[PosBits-1:0];
    o.frame_y = fr.y[PosBits-1:0];
    o.frame_w = fr.w[PosBits-1:0];
    o.frame_h = fr.h[PosBits-1:0];
    o.art_x = PosBits'(cv.x + ar.x);
    o.art_y = PosBits'(cv.y + ar.y);
    o.art_w = cv.w[PosBits-1:0];
    o.art_h = cv.h[PosBits-1:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  always @(posedge clk_i) begin
    res_t e;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("framed_cover_layout verification failed");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (layouts_due.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        e = layouts_due.pop_front();
        if (res_o.box_width != e.box_width)
          report_mismatch("box_width", res_o.box_width, e.box_width);
        if (res_o.box_height != e.box_height)
          report_mismatch("box_height", res_o.box_height, e.box_height);
        if (res_o.orientation != e.orientation)
          report_mismatch("orientation", res_o.orientation, e.orientation);
        if (res_o.frame_drawn != e.frame_drawn)
          report_mismatch("frame_drawn", res_o.frame_drawn, e.frame_drawn);
        if (res_o.frame_x != e.frame_x) report_mismatch("frame_x", res_o.frame_x, e.frame_x);
        if (res_o.frame_y != e.frame_y) report_mismatch("frame_y", res_o.frame_y, e.frame_y);
        if (res_o.frame_w != e.frame_w) report_mismatch("frame_w", res_o.frame_w, e.frame_w);
        if (res_o.frame_h != e.frame_h) report_mismatch("frame_h", res_o.frame_h, e.frame_h);
        if (res_o.art_x != e.art_x) report_mismatch("art_x", res_o.art_x, e.art_x);
        if (res_o.art_y != e.art_y) report_mismatch("art_y", res_o.art_y, e.art_y);
        if (res_o.art_w != e.art_w) report_mismatch("art_w", res_o.art_w, e.art_w);
        if (res_o.art_h != e.art_h) report_mismatch("art_h", res_o.art_h, e.art_h);
      end
    end
  end

  task automatic send_cover(logic [DimBits-1:0] w, logic [DimBits-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{art_width: w, art_height: h};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    layouts_due.push_back(predict_layout('{art_width: w, art_height: h}));
    @(negedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (layouts_due.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic write_border(reg_idx_e idx, logic [DataBits-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrBits'(4 * idx);
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegSqW:   borders.sq_w = value[DimBits-1:0];
      RegSqH:   borders.sq_h = value[DimBits-1:0];
      RegPortW: borders.port_w = value[DimBits-1:0];
      RegPortH: borders.port_h = value[DimBits-1:0];
      RegLandW: borders.land_w = value[DimBits-1:0];
      default:  borders.land_h = value[DimBits-1:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_borders(cfg_t c);
    write_border(RegSqW, DataBits'(c.sq_w));
    write_border(RegSqH, DataBits'(c.sq_h));
    write_border(RegPortW, DataBits'(c.port_w));
    write_border(RegPortH, DataBits'(c.port_h));
    write_border(RegLandW, DataBits'(c.land_w));
    write_border(RegLandH, DataBits'(c.land_h));
  endtask

  function automatic logic [DimBits-1:0] rand_dim();
    case ($urandom_range(3))
      0: return DimBits'($urandom_range(0, 100));
      1: return DimBits'($urandom_range(100, 2000));
      2: return DimBits'($urandom);
      default: return $urandom_range(1) ? '1 : DimBits'($urandom_range(1, 3));
    endcase
  endfunction

  task automatic test_directed_no_borders;
    send_cover(0, 0);
    send_cover('1, 0);
    send_cover(0, '1);
    send_cover('1, '1);
    send_cover(115, 100);
    send_cover(116, 100);
    send_cover(87, 100);
    send_cover(86, 100);
    send_cover(1, 1);
    send_cover(1, '1);
    send_cover('1, 1);
    drain();
  endtask

  task automatic test_directed_borders;
    load_borders('{sq_w: 0, sq_h: 0, port_w: 600, port_h: 900, land_w: 900, land_h: 500});
    send_cover(1920, 1080);
    send_cover(600, 900);
    send_cover(500, 500);
    send_cover(300, 0);
    drain();
    load_borders('{sq_w: 800, sq_h: 800, port_w: 40, port_h: 15, land_w: 20, land_h: 60});
    send_cover(1920, 1080);
    send_cover(600, 900);
    send_cover(500, 500);
    send_cover('1, '1);
    drain();
    load_borders('{sq_w: '1, sq_h: '1, port_w: '1, port_h: 1, land_w: 1, land_h: '1});
    send_cover(2, 1);
    send_cover(1, 2);
    send_cover(1, 1);
    send_cover('1, '1);
    drain();
  endtask

  task automatic test_random_layouts(int n);
    cfg_t c;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        drain();
        c = '{sq_w: rand_dim(), sq_h: rand_dim(), port_w: rand_dim(),
              port_h: rand_dim(), land_w: rand_dim(), land_h: rand_dim()};
        if ($urandom_range(1)) c.sq_w = 0;
        load_borders(c);
      end
      send_cover(rand_dim(), rand_dim());
    end
    drain();
  endtask

  initial begin
    borders = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_no_borders();
    test_directed_borders();
    send_idle_pct = 10;
    test_random_layouts(300);
    send_idle_pct = 86;
    test_random_layouts(300);
    send_idle_pct = 0;
    test_random_layouts(300);
    drain();
    if (errors == 0 && layouts_due.size() == 0) begin
      $display("framed_cover_layout verification clean");
    end else begin
      $display("framed_cover_layout verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
